FILE: rtl/text_card_crtc_shadow_assert.svh
// Assertion macros for the text card CRTC shadow.
// IMP checks a same-cycle implication, NXT checks it in the next cycle.
// Both sample on clk and are off while arst_n is low.
`ifndef TEXT_CARD_CRTC_SHADOW_ASSERT_SVH
`define TEXT_CARD_CRTC_SHADOW_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TCC_ASSERT_IMP(lbl, ante, cons, msg)
`define TCC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

	// item modes
	localparam logic [2:0] MODE_REG   = 3'd0;
	localparam logic [2:0] MODE_WIN   = 3'd1;
	localparam logic [2:0] MODE_SEL   = 3'd2;
	localparam logic [2:0] MODE_FLASH = 3'd3;
	localparam logic [2:0] MODE_DISP  = 3'd4;

	// video RAM geometry
	localparam int VRAM_DEPTH = 2048;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
	localparam int WIN_AW     = 9;
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 24;

	// display offset: row*COLUMNS + column + 14-bit start address
	localparam int OFF_W = 15;

	// bus window
	localparam logic [15:0] WINDOW_LOW = 16'hCC00;
	localparam logic [15:0] WINDOW_END = 16'hCE00;

	// cursor blink periods in microseconds
	localparam logic [63:0] FLASH_SHORT = 64'd312500;
	localparam logic [63:0] FLASH_LONG  = 64'd625000;
	localparam logic [7:0]  MASK_ON     = 8'hFF;
	localparam logic [7:0]  MASK_OFF    = 8'h00;

	// blink modes, register 10 bits 6:5
	localparam logic [1:0] BLINK_STEADY = 2'd0;
	localparam logic [1:0] BLINK_OFF    = 2'd1;
	localparam logic [1:0] BLINK_SLOW   = 2'd2;
	localparam logic [1:0] BLINK_FAST   = 2'd3;

	// controller register file
	localparam int CRTC_REGS = 17;
	localparam int IDX_W     = $clog2(CRTC_REGS);
	localparam int REG_CUR_START = 10;
	localparam int REG_CUR_END   = 11;
	localparam int REG_START_HI  = 12;
	localparam int REG_START_LO  = 13;
	localparam int REG_CUR_HI    = 14;
	localparam int REG_CUR_LO    = 15;

	localparam logic [7:0] CRTC_RESET [CRTC_REGS] = '{
		8'h7B, 8'h50, 8'h62, 8'h29, 8'h1B, 8'h08, 8'h18, 8'h19,
		8'h00, 8'h08, 8'hC0, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic [2:0]  mode;
		logic        bus_write;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
		logic [63:0] now_us;
		logic [4:0]  row;
		logic [6:0]  column;
		logic [3:0]  glyph_row;
	} in_word_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       cursor_hit;
		logic [7:0] cursor_xor;
		logic       memory_selected;
		logic [1:0] bank_now;
	} out_word_t;

	// video RAM request from the register stage
	typedef struct packed {
		logic               we;
		logic               re;
		logic [VRAM_AW-1:0] addr;
		logic [7:0]         wdata;
	} ram_req_t;

	// result fields known before the RAM read returns
	typedef struct packed {
		logic       disp;
		logic       cursor_hit;
		logic [7:0] cursor_xor;
		logic       memory_selected;
		logic [1:0] bank_now;
	} side_t;

endpackage

`default_nettype wire

FILE: rtl/tcc_ram.sv
`default_nettype none

module tcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read, read data holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tcc_regs.sv
`default_nettype none

module tcc_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  tcc_pkg::in_word_t item,
	output tcc_pkg::ram_req_t req,
	output tcc_pkg::side_t    side
);
	import tcc_pkg::*;

	logic [1:0]  bank_q;
	logic [1:0]  bank_d;
	logic [7:0]  reg_index_q;
	logic [7:0]  crtc_q [CRTC_REGS];
	logic        window_q;
	logic        window_d;
	logic [7:0]  mask_q;
	logic [63:0] nft_q;

	logic is_reg, is_win, is_sel, is_flash, is_disp;
	logic in_window, win_store, win_close;
	logic flash_due;
	logic [63:0] sum_short, sum_long;
	logic [1:0]  blink;
	logic [13:0] start_addr, cur_addr;
	logic [OFF_W-1:0] off;
	logic glyph_in;

	// mode decode
	assign is_reg   = item.mode == MODE_REG;
	assign is_win   = item.mode == MODE_WIN;
	assign is_sel   = item.mode == MODE_SEL;
	assign is_flash = item.mode == MODE_FLASH;
	assign is_disp  = item.mode == MODE_DISP;

	// window decode
	assign in_window = is_win && window_q && (item.bus_address >= WINDOW_LOW);
	assign win_store = in_window && (item.bus_address < WINDOW_END) && item.bus_write;
	assign win_close = in_window && (item.bus_address >= WINDOW_END);

	assign bank_d   = is_reg ? item.bus_address[3:2] : bank_q;
	assign window_d = is_sel ? 1'b1 : (win_close ? 1'b0 : window_q);

	// flash timing
	assign flash_due = is_flash && (item.now_us > nft_q);
	assign sum_short = item.now_us + FLASH_SHORT;
	assign sum_long  = item.now_us + FLASH_LONG;
	assign blink     = crtc_q[REG_CUR_START][6:5];

	// display position and cursor
	assign start_addr = {crtc_q[REG_START_HI][5:0], crtc_q[REG_START_LO]};
	assign cur_addr   = {crtc_q[REG_CUR_HI][5:0], crtc_q[REG_CUR_LO]};
	assign off = OFF_W'(item.row) * OFF_W'(COLUMNS) + OFF_W'(item.column)
		+ OFF_W'(start_addr);
	assign glyph_in = (item.glyph_row >= crtc_q[REG_CUR_START][3:0])
		&& (item.glyph_row <= crtc_q[REG_CUR_END][3:0]);

	// RAM request
	always_comb begin
		req.we    = win_store;
		req.re    = is_disp;
		req.addr  = win_store ? {bank_q, item.bus_address[WIN_AW-1:0]}
			: off[VRAM_AW-1:0];
		req.wdata = item.bus_data;
	end

	// early result fields
	always_comb begin
		side.disp            = is_disp;
		side.cursor_hit      = is_disp && (OFF_W'(cur_addr) == off) && glyph_in;
		side.cursor_xor      = side.cursor_hit ? mask_q : MASK_OFF;
		side.memory_selected = window_d;
		side.bank_now        = bank_d;
	end

	// state update, one item per fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= '0;
			reg_index_q <= '0;
			crtc_q      <= CRTC_RESET;
			window_q    <= 1'b0;
			mask_q      <= MASK_OFF;
			nft_q       <= '0;
		end else if (fire) begin
			bank_q   <= bank_d;
			window_q <= window_d;
			if (is_reg && item.bus_write) begin
				if (item.bus_address[0]) begin
					if (reg_index_q < 8'(CRTC_REGS)) begin
						crtc_q[reg_index_q[IDX_W-1:0]] <= item.bus_data;
					end
				end else begin
					reg_index_q <= item.bus_data;
				end
			end
			if (flash_due) begin
				case (blink)
					BLINK_STEADY: begin
						mask_q <= MASK_ON;
						nft_q  <= sum_short;
					end
					BLINK_OFF: begin
						mask_q <= MASK_OFF;
						nft_q  <= sum_short;
					end
					BLINK_SLOW: begin
						mask_q <= ~mask_q;
						nft_q  <= sum_long;
					end
					default: begin
						mask_q <= ~mask_q;
						nft_q  <= sum_short;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/text_card_crtc_shadow.sv
// Text card CRTC shadow.
// Command channel (cmd_valid / cmd_stall / cmd) takes one word per item:
// register access, window access, memory select, cursor flash update or
// display read. Result channel (res_valid / res_stall / res) returns
// exactly one word per command, in order.
// Each accepted command passes the input register, then the video RAM's
// registered read, then the result register, before res_valid rises.
// Throughput: one word per cycle unless res_stall or the RAM clearing
// pass holds it; the single video RAM port serves one access per item.
// When res_stall is high the result register holds, and the two stages
// behind it still fill, so up to two more commands are taken before
// cmd_stall rises.
// After reset the video RAM is cleared one entry per cycle; cmd_stall
// stays high until all 2048 entries are clear. Registers reset at once.
`default_nettype none
`include "text_card_crtc_shadow_assert.svh"

module text_card_crtc_shadow (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  tcc_pkg::in_word_t  cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output tcc_pkg::out_word_t res
);
	import tcc_pkg::*;

	logic [VRAM_AW:0] clr_cnt_q;
	logic             clear_busy;

	logic     valid_s1_q;
	in_word_t item_s1;
	logic     valid_s2_q;
	side_t    side_s2;
	logic     res_valid_q;
	out_word_t res_q;

	logic out_take, s2_take, s1_take, fire_s1, accept;

	ram_req_t         req;
	side_t            side;
	logic             ram_we, ram_re;
	logic [VRAM_AW-1:0] ram_addr;
	logic [7:0]       ram_wdata, ram_rdata;

	// clearing pass after reset
	assign clear_busy = !clr_cnt_q[VRAM_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clear_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// flow control
	assign out_take  = !res_valid_q || !res_stall;
	assign s2_take   = !valid_s2_q || out_take;
	assign s1_take   = !valid_s1_q || s2_take;
	assign fire_s1   = valid_s1_q && s2_take;
	assign cmd_stall = clear_busy || !s1_take;
	assign accept    = cmd_valid && !cmd_stall;

	tcc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.req    (req),
		.side   (side)
	);

	// RAM port: clearing pass or the item in stage 1
	assign ram_we    = clear_busy || (fire_s1 && req.we);
	assign ram_re    = fire_s1 && req.re;
	assign ram_addr  = clear_busy ? clr_cnt_q[VRAM_AW-1:0] : req.addr;
	assign ram_wdata = clear_busy ? 8'h00 : req.wdata;

	tcc_ram #(
		.WIDTH (8),
		.DEPTH (VRAM_DEPTH)
	) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			valid_s2_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				valid_s1_q <= accept;
			end
			if (s2_take) begin
				valid_s2_q <= valid_s1_q;
			end
			if (out_take) begin
				res_valid_q <= valid_s2_q;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
		if (fire_s1) begin
			side_s2 <= side;
		end
		if (out_take && valid_s2_q) begin
			res_q.char_code       <= side_s2.disp ? ram_rdata : 8'h00;
			res_q.cursor_hit      <= side_s2.cursor_hit;
			res_q.cursor_xor      <= side_s2.cursor_xor;
			res_q.memory_selected <= side_s2.memory_selected;
			res_q.bank_now        <= side_s2.bank_now;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	`TCC_ASSERT_IMP(a_clear_empty, clear_busy, !valid_s1_q && !valid_s2_q && !res_valid_q, "pipeline busy during RAM clear")
	`TCC_ASSERT_NXT(a_s2_hold, valid_s2_q && side_s2.disp && !s2_take, valid_s2_q && $stable(ram_rdata), "stalled read data lost")
	`TCC_ASSERT_NXT(a_disp_lands, fire_s1 && item_s1.mode == MODE_DISP, valid_s2_q && side_s2.disp, "display read did not reach stage 2")

endmodule

`default_nettype wire
